// ----- hw/rtl/lsbs_pkg.sv -----
// shared types and constants for the longest subarray by sum unit
package lsbs_pkg;

  localparam int IN_W      = 16;
  localparam int TGT_W     = 27;
  localparam int POS_OUT_W = 11;
  localparam int EPOCH_W   = 8;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // fibonacci hashing multiplier, split in halves
  localparam logic [31:0] GOLD_HI = 32'h9E3779B9;
  localparam logic [31:0] GOLD_LO = 32'h7F4A7C15;

  // register index, taken from paddr bit 2
  localparam logic REG_TARGET_SUM = 1'b0;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_HASH = 6'b000100,
    S_RD   = 6'b001000,
    S_CMP  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  typedef enum logic [2:0] {
    OP_INS0 = 3'b001,
    OP_INS  = 3'b010,
    OP_FIND = 3'b100
  } op_e;

  typedef enum logic [6:0] {
    H_IDLE = 7'b0000001,
    H_MUL0 = 7'b0000010,
    H_MUL1 = 7'b0000100,
    H_MUL2 = 7'b0001000,
    H_QUOT = 7'b0010000,
    H_REM  = 7'b0100000,
    H_FIX  = 7'b1000000
  } hstate_e;

endpackage

// ----- hw/rtl/lsbs_if.sv -----
// valid/ready channels for input elements and results
interface lsbs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lsbs_pkg::IN_W-1:0]     element_value;
  logic                                 is_last;

  modport source (output valid, element_value, is_last, input ready);
  modport sink (input valid, element_value, is_last, output ready);
endinterface

interface lsbs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 found;
  logic [lsbs_pkg::POS_OUT_W-1:0]       start_pos;
  logic [lsbs_pkg::POS_OUT_W-1:0]       end_pos;
  logic                                 overflow;

  modport source (output valid, found, start_pos, end_pos, overflow, input ready);
  modport sink (input valid, found, start_pos, end_pos, overflow, output ready);
endinterface

// ----- hw/rtl/lsbs_ram.sv -----
// generic single-port ram with registered read
module lsbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/lsbs_hash.sv -----
// multi-cycle home slot hash: 64-bit fibonacci product, high word modulo slot count
module lsbs_hash #(
  parameter int KEY_W = 28,
  parameter int SLOTS = 2048
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [KEY_W-1:0]  key_i,
  output logic                     done_o,
  output logic [$clog2(SLOTS)-1:0] slot_o
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int SH    = 32 + $clog2(SLOTS);
  localparam logic [33:0] RECIP = 34'((66'd1 << SH) / 66'(SLOTS));
  localparam logic [31:0] SLOTS_W = 32'(SLOTS);

  lsbs_pkg::hstate_e state_q, state_d;
  logic              done_q;
  logic [63:0]       key_q;
  logic [63:0]       pa_q;
  logic [31:0]       acc_q;
  logic [31:0]       quot_q;
  logic [31:0]       rem_q;
  logic [IDX_W-1:0]  slot_q;

  logic [63:0] mul_kl_hi;
  logic [63:0] mul_kh_lo;
  logic [65:0] quot_full;
  logic [63:0] rem_full;
  logic [31:0] rem_fix;

  assign mul_kl_hi = key_q[31:0] * lsbs_pkg::GOLD_HI;
  assign mul_kh_lo = key_q[63:32] * lsbs_pkg::GOLD_LO;
  assign quot_full = 66'(acc_q) * 66'(RECIP);
  assign rem_full  = quot_q * SLOTS_W;
  assign rem_fix   = (rem_q >= SLOTS_W) ? (rem_q - SLOTS_W) : rem_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lsbs_pkg::H_IDLE: if (start_i) state_d = lsbs_pkg::H_MUL0;
      lsbs_pkg::H_MUL0: state_d = lsbs_pkg::H_MUL1;
      lsbs_pkg::H_MUL1: state_d = lsbs_pkg::H_MUL2;
      lsbs_pkg::H_MUL2: state_d = lsbs_pkg::H_QUOT;
      lsbs_pkg::H_QUOT: state_d = lsbs_pkg::H_REM;
      lsbs_pkg::H_REM:  state_d = lsbs_pkg::H_FIX;
      lsbs_pkg::H_FIX:  state_d = lsbs_pkg::H_IDLE;
      default:          state_d = lsbs_pkg::H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsbs_pkg::H_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == lsbs_pkg::H_FIX);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      lsbs_pkg::H_IDLE: if (start_i) key_q <= 64'(key_i);
      lsbs_pkg::H_MUL0: pa_q <= key_q[31:0] * lsbs_pkg::GOLD_LO;
      lsbs_pkg::H_MUL1: acc_q <= pa_q[63:32] + mul_kl_hi[31:0];
      lsbs_pkg::H_MUL2: acc_q <= acc_q + mul_kh_lo[31:0];
      lsbs_pkg::H_QUOT: quot_q <= 32'(quot_full >> SH);
      lsbs_pkg::H_REM:  rem_q <= acc_q - rem_full[31:0];
      lsbs_pkg::H_FIX:  slot_q <= rem_fix[IDX_W-1:0];
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign slot_o = slot_q;

endmodule

// ----- hw/rtl/longest_subarray_by_sum_unit.sv -----
// top level: longest subarray with a given sum over a hashed prefix-sum table
// table operation: the hash, a read and a compare, plus a read and a compare per extra probe
// flow: one element at a time; each element within the length limit takes an insert and a
//   lookup, and an array's first element also takes an extra insert of sum zero
// reset: control clears at once, then a sweep over every slot clears the table tags before
//   the first element; the sweep repeats after every 255 arrays
module longest_subarray_by_sum_unit #(
  parameter int MAX_LEN    = 1024,
  parameter int HASH_SLOTS = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lsbs_in_if.sink                       in_i,
  lsbs_out_if.source                    out_o,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [lsbs_pkg::PADDR_W-1:0]  paddr_i,
  input  logic [lsbs_pkg::PDATA_W-1:0]  pwdata_i,
  output logic [lsbs_pkg::PDATA_W-1:0]  prdata_o,
  output logic                          pready_o
);

  localparam int POS_W  = $clog2(MAX_LEN + 1);
  localparam int SUM_W  = 17 + $clog2(MAX_LEN);
  localparam int TGT_W  = lsbs_pkg::TGT_W;
  localparam int KEY_W  = ((SUM_W > TGT_W) ? SUM_W : TGT_W) + 1;
  localparam int IDX_W  = $clog2(HASH_SLOTS);
  localparam int EP_W   = lsbs_pkg::EPOCH_W;
  localparam int WORD_W = EP_W + SUM_W + POS_W;
  localparam int OUT_W  = lsbs_pkg::POS_OUT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HASH_SLOTS - 1);

  // config register
  logic signed [TGT_W-1:0] tgt_reg_q;
  logic                    cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  assign prdata_o = (paddr_i[2] == lsbs_pkg::REG_TARGET_SUM) ?
                    lsbs_pkg::PDATA_W'(tgt_reg_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_reg_q <= '0;
    end else if (cfg_wr && (paddr_i[2] == lsbs_pkg::REG_TARGET_SUM)) begin
      tgt_reg_q <= pwdata_i[TGT_W-1:0];
    end
  end

  // control state
  lsbs_pkg::state_e state_q, state_d;
  lsbs_pkg::op_e    op_q, op_d;
  logic [POS_W-1:0] count_q, count_d;
  logic             found_q, found_d;
  logic             dropped_q, dropped_d;
  logic [EP_W-1:0]  epoch_q, epoch_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic             out_valid_q, out_valid_d;

  // datapath state
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [TGT_W-1:0] target_q, target_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic                    last_q, last_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [IDX_W-1:0]        probe_q, probe_d;
  logic [POS_W-1:0]        best_len_q, best_len_d;
  logic [POS_W-1:0]        best_start_q, best_start_d;
  logic [POS_W-1:0]        best_end_q, best_end_d;
  logic                    out_found_q, out_found_d;
  logic [OUT_W-1:0]        out_start_q, out_start_d;
  logic [OUT_W-1:0]        out_end_q, out_end_d;
  logic                    out_ovf_q, out_ovf_d;

  // hash unit
  logic                    hash_start;
  logic signed [KEY_W-1:0] hash_key;
  logic                    hash_done;
  logic [IDX_W-1:0]        hash_slot;

  lsbs_hash #(
    .KEY_W (KEY_W),
    .SLOTS (HASH_SLOTS)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (hash_key),
    .done_o  (hash_done),
    .slot_o  (hash_slot)
  );

  // table memory: {epoch tag, prefix sum, first position}
  logic              mem_we;
  logic [IDX_W-1:0]  mem_addr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  lsbs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (HASH_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  logic [EP_W-1:0]         rd_epoch;
  logic signed [SUM_W-1:0] rd_sum;
  logic [POS_W-1:0]        rd_pos;
  logic                    rd_live;
  logic                    rd_hit;
  logic [IDX_W-1:0]        next_idx;
  logic                    exhausted;
  logic [POS_W-1:0]        span_len;
  logic                    in_xfer;
  logic                    out_xfer;

  assign rd_epoch  = mem_rdata[WORD_W-1 -: EP_W];
  assign rd_sum    = mem_rdata[POS_W +: SUM_W];
  assign rd_pos    = mem_rdata[POS_W-1:0];
  // a slot counts only if tagged with the current array's epoch
  assign rd_live   = (rd_epoch == epoch_q);
  assign rd_hit    = rd_live && (KEY_W'(rd_sum) == key_q);
  assign next_idx  = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
  assign exhausted = (probe_q == LAST_IDX);
  assign span_len  = count_q - rd_pos;

  assign in_i.ready = (state_q == lsbs_pkg::S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_valid_q && out_o.ready;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    count_d      = count_q;
    found_d      = found_q;
    dropped_d    = dropped_q;
    epoch_d      = epoch_q;
    clr_d        = clr_q;
    out_valid_d  = out_xfer ? 1'b0 : out_valid_q;
    sum_d        = sum_q;
    target_d     = target_q;
    key_d        = key_q;
    last_d       = last_q;
    idx_d        = idx_q;
    probe_d      = probe_q;
    best_len_d   = best_len_q;
    best_start_d = best_start_q;
    best_end_d   = best_end_q;
    out_found_d  = out_found_q;
    out_start_d  = out_start_q;
    out_end_d    = out_end_q;
    out_ovf_d    = out_ovf_q;
    hash_start   = 1'b0;
    hash_key     = key_q;
    mem_we       = 1'b0;
    mem_addr     = idx_q;
    mem_wdata    = {epoch_q, SUM_W'(key_q), ((op_q == lsbs_pkg::OP_INS0) ? '0 : count_q)};

    case (state_q)
      lsbs_pkg::S_CLR: begin
        // tag sweep: epoch zero is never a live epoch
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LAST_IDX) begin
          state_d = lsbs_pkg::S_IDLE;
        end
      end
      lsbs_pkg::S_IDLE: begin
        if (in_xfer) begin
          last_d   = in_i.is_last;
          target_d = tgt_reg_q;
          if (count_q >= POS_W'(MAX_LEN)) begin
            // past the length limit: only flag it
            dropped_d = 1'b1;
            state_d   = lsbs_pkg::S_DONE;
          end else begin
            count_d    = count_q + 1'b1;
            sum_d      = sum_q + SUM_W'(in_i.element_value);
            hash_start = 1'b1;
            state_d    = lsbs_pkg::S_HASH;
            if (count_q == '0) begin
              // first element: put sum zero at position zero
              op_d     = lsbs_pkg::OP_INS0;
              key_d    = '0;
              hash_key = '0;
              if ((tgt_reg_q == '0) && !found_q) begin
                found_d      = 1'b1;
                best_len_d   = '0;
                best_start_d = POS_W'(1);
                best_end_d   = '0;
              end
            end else begin
              op_d     = lsbs_pkg::OP_INS;
              key_d    = KEY_W'(sum_d);
              hash_key = KEY_W'(sum_d);
            end
          end
        end
      end
      lsbs_pkg::S_HASH: begin
        if (hash_done) begin
          idx_d   = hash_slot;
          probe_d = '0;
          state_d = lsbs_pkg::S_RD;
        end
      end
      lsbs_pkg::S_RD: begin
        state_d = lsbs_pkg::S_CMP;
      end
      lsbs_pkg::S_CMP: begin
        if (op_q == lsbs_pkg::OP_FIND) begin
          if (rd_hit) begin
            if ((rd_pos <= count_q) && (!found_q || (span_len > best_len_q))) begin
              found_d      = 1'b1;
              best_len_d   = span_len;
              best_start_d = rd_pos + 1'b1;
              best_end_d   = count_q;
            end
            state_d = lsbs_pkg::S_DONE;
          end else if (!rd_live || exhausted) begin
            state_d = lsbs_pkg::S_DONE;
          end else begin
            idx_d   = next_idx;
            probe_d = probe_q + 1'b1;
            state_d = lsbs_pkg::S_RD;
          end
        end else begin
          if (!rd_live || rd_hit || exhausted) begin
            // free slot takes the key; a hit or a full table leaves it as is
            mem_we     = !rd_live;
            hash_start = 1'b1;
            state_d    = lsbs_pkg::S_HASH;
            if (op_q == lsbs_pkg::OP_INS0) begin
              op_d     = lsbs_pkg::OP_INS;
              key_d    = KEY_W'(sum_q);
              hash_key = KEY_W'(sum_q);
            end else begin
              op_d     = lsbs_pkg::OP_FIND;
              key_d    = KEY_W'(sum_q) - KEY_W'(target_q);
              hash_key = KEY_W'(sum_q) - KEY_W'(target_q);
            end
          end else begin
            idx_d   = next_idx;
            probe_d = probe_q + 1'b1;
            state_d = lsbs_pkg::S_RD;
          end
        end
      end
      lsbs_pkg::S_DONE: begin
        if (!last_q) begin
          state_d = lsbs_pkg::S_IDLE;
        end else if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_found_d  = found_q;
          out_start_d  = found_q ? OUT_W'(best_start_q) : '0;
          out_end_d    = found_q ? OUT_W'(best_end_q) : '0;
          out_ovf_d    = dropped_q;
          // per-array clear: a new epoch retires every slot at once
          sum_d        = '0;
          count_d      = '0;
          found_d      = 1'b0;
          dropped_d    = 1'b0;
          best_len_d   = '0;
          best_start_d = '0;
          best_end_d   = '0;
          if (epoch_q == '1) begin
            epoch_d = EP_W'(1);
            clr_d   = '0;
            state_d = lsbs_pkg::S_CLR;
          end else begin
            epoch_d = epoch_q + 1'b1;
            state_d = lsbs_pkg::S_IDLE;
          end
        end
      end
      default: state_d = lsbs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lsbs_pkg::S_CLR;
      op_q         <= lsbs_pkg::OP_INS0;
      count_q      <= '0;
      found_q      <= 1'b0;
      dropped_q    <= 1'b0;
      epoch_q      <= EP_W'(1);
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
      sum_q        <= '0;
      last_q       <= 1'b0;
      best_len_q   <= '0;
      best_start_q <= '0;
      best_end_q   <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      count_q      <= count_d;
      found_q      <= found_d;
      dropped_q    <= dropped_d;
      epoch_q      <= epoch_d;
      clr_q        <= clr_d;
      out_valid_q  <= out_valid_d;
      sum_q        <= sum_d;
      last_q       <= last_d;
      best_len_q   <= best_len_d;
      best_start_q <= best_start_d;
      best_end_q   <= best_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q    <= target_d;
    key_q       <= key_d;
    idx_q       <= idx_d;
    probe_q     <= probe_d;
    out_found_q <= out_found_d;
    out_start_q <= out_start_d;
    out_end_q   <= out_end_d;
    out_ovf_q   <= out_ovf_d;
  end

  // result transfer register
  assign out_o.valid     = out_valid_q;
  assign out_o.found     = out_found_q;
  assign out_o.start_pos = out_start_q;
  assign out_o.end_pos   = out_end_q;
  assign out_o.overflow  = out_ovf_q;

endmodule

// ----- hw/rtl/lsbs_checker.sv -----
// port-level checks for the longest subarray by sum unit, bound to the top level
module lsbs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_found,
  input logic [lsbs_pkg::POS_OUT_W-1:0] out_start,
  input logic [lsbs_pkg::POS_OUT_W-1:0] out_end,
  input logic                           out_ovf
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_start)
      && $stable(out_end) && $stable(out_ovf))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("element taken while one is in work");

  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_found |-> (out_start == '0) && (out_end == '0))
    else $error("empty result carries a span");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_found |-> (out_start != '0)
      && ((lsbs_pkg::POS_OUT_W + 1)'(out_start) <= (lsbs_pkg::POS_OUT_W + 1)'(out_end) + 1'b1))
    else $error("found span out of order");

endmodule

bind longest_subarray_by_sum_unit lsbs_checker u_lsbs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_found (out_o.found),
  .out_start (out_o.start_pos),
  .out_end   (out_o.end_pos),
  .out_ovf   (out_o.overflow)
);

// ----- verif/longest_subarray_by_sum_unit_tb.sv -----
// testbench for the longest subarray by sum unit: directed and random arrays, self-checking
`timescale 1ns / 100ps

module longest_subarray_by_sum_unit_tb;

  typedef struct {
    logic signed [lsbs_pkg::IN_W-1:0] value;
    logic                             last;
  } element_t;

  typedef struct {
    logic                           found;
    logic [lsbs_pkg::POS_OUT_W-1:0] start_pos;
    logic [lsbs_pkg::POS_OUT_W-1:0] end_pos;
    logic                           overflow;
  } span_t;

  localparam int  MAX_LEN     = 1024;
  localparam int  SETTLE      = 120;     // cycles for the block to go quiet
  localparam int  CYCLE_LIMIT = 900000;
  localparam longint TGT_MAX  = 33554431;
  localparam longint TGT_MIN  = -33554432;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // configuration port
  logic                          psel_i = 1'b0;
  logic                          penable_i = 1'b0;
  logic                          pwrite_i = 1'b0;
  logic [lsbs_pkg::PADDR_W-1:0]  paddr_i = '0;
  logic [lsbs_pkg::PDATA_W-1:0]  pwdata_i = '0;
  logic [lsbs_pkg::PDATA_W-1:0]  prdata_o;
  logic                          pready_o;

  lsbs_in_if  elem_bus ();
  lsbs_out_if span_bus ();

  longest_subarray_by_sum_unit dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (elem_bus),
    .out_o     (span_bus),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // elements waiting to be sent, and spans the block still owes us
  element_t pending_elems[$];
  span_t    owed_spans[$];

  // our own copy of the block's state
  longint target_copy;
  longint prefix_sum;
  int     elem_count;
  int     first_pos_of_sum[longint];
  int     best_len;
  int     best_first;
  int     best_last;
  bit     dropped;

  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;   // no idling in the closing part
  int  send_gap = 0;
  int  stall_left = 0;

  initial begin
    elem_bus.valid = 1'b0;
    elem_bus.element_value = '0;
    elem_bus.is_last = 1'b0;
    span_bus.ready = 1'b0;
  end

  task automatic forget_array();
    prefix_sum = 0;
    elem_count = 0;
    first_pos_of_sum.delete();
    best_len = -1;
    best_first = 0;
    best_last = 0;
    dropped = 1'b0;
  endtask

  // work out the span for one accepted element; returns a result on the last one
  task automatic track_element(input element_t e);
    longint want;
    int     left;
    int     len;
    span_t  s;
    if (elem_count == 0 && !dropped) begin
      if (!first_pos_of_sum.exists(0)) first_pos_of_sum[0] = 0;
      // zero target: the empty span counts as found right away
      if (target_copy == 0 && best_len < 0) begin
        best_len = 0;
        best_first = 1;
        best_last = 0;
      end
    end
    if (elem_count >= MAX_LEN) begin
      dropped = 1'b1;
    end else begin
      elem_count++;
      prefix_sum += longint'(e.value);
      if (!first_pos_of_sum.exists(prefix_sum)) first_pos_of_sum[prefix_sum] = elem_count;
      want = prefix_sum - target_copy;
      if (first_pos_of_sum.exists(want)) begin
        left = first_pos_of_sum[want];
        len = elem_count - left;
        if (len > best_len) begin
          best_len = len;
          best_first = left + 1;
          best_last = elem_count;
        end
      end
    end
    if (e.last) begin
      s.found = best_len >= 0;
      s.start_pos = s.found ? lsbs_pkg::POS_OUT_W'(best_first) : '0;
      s.end_pos = s.found ? lsbs_pkg::POS_OUT_W'(best_last) : '0;
      s.overflow = dropped;
      owed_spans.push_back(s);
      forget_array();
    end
  endtask

  // sender: holds valid until the transfer, random gaps between elements
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!elem_bus.valid || elem_bus.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          elem_bus.valid <= 1'b0;
        end else if (pending_elems.size() > 0) begin
          elem_bus.valid <= 1'b1;
          elem_bus.element_value <= pending_elems[0].value;
          elem_bus.is_last <= pending_elems[0].last;
          void'(pending_elems.pop_front());
          if (!calm && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 18);
        end else begin
          elem_bus.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: ready drops in random bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        span_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left <= $urandom_range(0, 17);
        span_bus.ready <= 1'b0;
      end else begin
        span_bus.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on each element transfer, check each result transfer
  always @(posedge clk_i) begin
    element_t e;
    span_t    got;
    span_t    exp_s;
    cycle_count <= cycle_count + 1;
    if (elem_bus.valid && elem_bus.ready) begin
      e.value = elem_bus.element_value;
      e.last = elem_bus.is_last;
      track_element(e);
    end
    if (span_bus.valid && span_bus.ready) begin
      got.found = span_bus.found;
      got.start_pos = span_bus.start_pos;
      got.end_pos = span_bus.end_pos;
      got.overflow = span_bus.overflow;
      if (owed_spans.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: found=%0d start=%0d end=%0d overflow=%0d",
                   got.found, got.start_pos, got.end_pos, got.overflow);
      end else begin
        exp_s = owed_spans.pop_front();
        if (got.found !== exp_s.found || got.start_pos !== exp_s.start_pos ||
            got.end_pos !== exp_s.end_pos || got.overflow !== exp_s.overflow) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result mismatch: expected found=%0d start=%0d end=%0d overflow=%0d,",
                      " got found=%0d start=%0d end=%0d overflow=%0d"},
                     exp_s.found, exp_s.start_pos, exp_s.end_pos, exp_s.overflow,
                     got.found, got.start_pos, got.end_pos, got.overflow);
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic put(input int v, input bit last);
    element_t e;
    e.value = lsbs_pkg::IN_W'(v);
    e.last = last;
    pending_elems.push_back(e);
  endtask

  // mostly small values so prefix sums repeat, sometimes full range
  task automatic put_array(input int len);
    int v;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) v = int'($signed(16'($urandom)));
      else v = $urandom_range(0, 8) - 4;
      put(v, i == len - 1);
    end
  endtask

  // wait until every element went out and the block finished its work
  task automatic drain();
    while (pending_elems.size() > 0 || elem_bus.valid || owed_spans.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // write of the target register: setup phase, then access phase
  task automatic set_target(input longint t);
    @(posedge clk_i);
    psel_i <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i <= 1'b1;
    paddr_i <= {lsbs_pkg::REG_TARGET_SUM, 2'b00};
    pwdata_i <= lsbs_pkg::PDATA_W'(t);
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
    target_copy = t;
  endtask

  initial begin
    int     sent;
    longint t;
    target_copy = 0;
    forget_array();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero target after reset: empty span found at once
    put(5, 1);
    put(32767, 0); put(-32768, 0); put(1, 1);
    put(0, 1);
    put(3, 0); put(-3, 0); put(2, 0); put(-2, 1);
    drain();

    set_target(7);
    put(3, 0); put(4, 0); put(7, 1);
    put(1, 0); put(2, 1);
    // target changed mid-array
    put(7, 0); put(0, 0);
    drain();
    set_target(-5);
    put(-2, 0); put(-3, 1);
    drain();

    // large targets, 2^25 - 1 and -2^25: out of reach
    set_target(TGT_MAX);
    put(32767, 0); put(32767, 1);
    drain();
    set_target(TGT_MIN);
    put(-32768, 1);
    drain();

    // too many elements: the tail is dropped, last still closes the array
    set_target(1);
    put_array(MAX_LEN + 6);
    drain();

    // random phases with fresh targets
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0: t = 0;
        1: t = longint'($urandom_range(0, 12)) - 6;
        2: t = longint'($signed(27'($urandom)));
        default: t = longint'($urandom_range(0, 400)) - 200;
      endcase
      if (ph == 7) calm = 1'b1;
      set_target(t);
      for (int k = 0; k < 10; k += 0) begin
        int len;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
        put_array(len);
        k += len;
        sent += len;
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lsbs_pkg.sv
hw/rtl/lsbs_if.sv
hw/rtl/lsbs_ram.sv
hw/rtl/lsbs_hash.sv
hw/rtl/longest_subarray_by_sum_unit.sv
hw/rtl/lsbs_checker.sv
verif/longest_subarray_by_sum_unit_tb.sv
